// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Slot record, per-cycle control to the cell row, status and request codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned STAT_W = 2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_ENQ   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DEQ   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } slot_t;

  typedef struct packed {
    logic              insert;
    logic              remove;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted cell row
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor; on remove it takes its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire ctrl_t ctrl_i,
  input  wire slot_t left_i,
  input  wire logic  left_ins_i,
  input  wire slot_t right_i,
  output      slot_t slot_o,
  output      logic  ins_o
);

  logic              valid_q, valid_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [PRIO_W-1:0] prio_q, prio_d;

  assign ins_o  = !valid_q || (prio_q > ctrl_i.prio);
  assign slot_o = '{valid: valid_q, data: data_q, prio: prio_q};

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    prio_d  = prio_q;
    if (ctrl_i.insert && ins_o) begin
      if (left_ins_i) begin
        valid_d = left_i.valid;
        data_d  = left_i.data;
        prio_d  = left_i.prio;
      end else begin
        valid_d = 1'b1;
        data_d  = ctrl_i.data;
        prio_d  = ctrl_i.prio;
      end
    end else if (ctrl_i.remove) begin
      valid_d = right_i.valid;
      data_d  = right_i.data;
      prio_d  = right_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/stable_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_top: bounded sorted priority queue
// Row of DEPTH cells kept in ascending priority order, FIFO among equals.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis: tuser is the kind (0 enqueue, 1 dequeue),
//   tdata carries the data word and its priority. Each request yields one
//   result on m_axis: tdata is the dequeued word (-1 on empty, 0 on any
//   enqueue), tuser carries the status and the now-empty flag.
//   The result is registered in the cycle after its request is taken. One
//   request is taken per cycle unless the receiver stalls; every cell compares
//   its priority against the request in parallel and shifts in the same cycle.
//   The result sits in an output register; a new request is taken whenever
//   that register is empty or being drained in the same cycle. While the
//   receiver stalls with a result held, s_axis_tready stays low.
//   Reset empties the queue and the output register; slot payloads are not
//   cleared, only their valid bits.
//   An enqueue into a full queue is dropped with status 3.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue_top
  import spq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // [31:0] item_data, [47:32] item_priority
  input  wire logic        s_axis_tuser,  // [0] kind
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,  // [31:0] out_data
  output      logic [2:0]  m_axis_tuser   // [1:0] status, [2] now_empty
);

  slot_t             slot   [DEPTH];
  logic [DEPTH-1:0]  ins;
  ctrl_t             ctrl;
  logic              accept;
  logic              head_valid, second_valid, full;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              empty_q, empty_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign head_valid   = slot[0].valid;
  assign second_valid = slot[1].valid;
  assign full         = slot[DEPTH-1].valid;

  assign ctrl.insert = accept && (s_axis_tuser == KIND_ENQ) && !full;
  assign ctrl.remove = accept && (s_axis_tuser == KIND_DEQ) && head_valid;
  assign ctrl.data   = s_axis_tdata[DATA_W-1:0];
  assign ctrl.prio   = s_axis_tdata[DATA_W+PRIO_W-1:DATA_W];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t left_s, right_s;
    logic  left_ins;
    if (i == 0) begin : g_first
      assign left_s   = '0;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_s   = slot[i-1];
      assign left_ins = ins[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_s = '0;
    end else begin : g_body
      assign right_s = slot[i+1];
    end
    spq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .left_i     (left_s),
      .left_ins_i (left_ins),
      .right_i    (right_s),
      .slot_o     (slot[i]),
      .ins_o      (ins[i])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    status_d    = status_q;
    empty_d     = empty_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      if (s_axis_tuser == KIND_ENQ) begin
        out_data_d = '0;
        status_d   = full ? ST_FULL : ST_ENQ;
        empty_d    = 1'b0;
      end else if (head_valid) begin
        out_data_d = slot[0].data;
        status_d   = ST_DEQ;
        empty_d    = !second_valid;
      end else begin
        out_data_d = '1;
        status_d   = ST_EMPTY;
        empty_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    status_q   <= status_d;
    empty_q    <= empty_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {empty_q, status_q};

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[1:0] == ST_EMPTY))
      |-> ((m_axis_tdata == '1) && m_axis_tuser[2]))
    else $error("dequeue on empty must return -1 and report empty");

  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !slot[0].valid |-> !slot[1].valid)
    else $error("queue entries must stay packed at the head");

  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot[0].valid && slot[1].valid) |-> (slot[0].prio <= slot[1].prio))
    else $error("head entries out of priority order");

  a_enq_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> head_valid)
    else $error("enqueue must leave the queue non-empty");

endmodule

`default_nettype wire

// ===== tb/sv/stable_priority_queue_top_test.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_top_test: self-checking bench for the priority queue
// Streams enqueue and dequeue requests with random gaps and receiver stalls,
// predicts every result from a shadow copy of the sorted slots, and compares
// each result field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue_top_test;
  import spq_pkg::*;

  localparam int IDLE_LIMIT  = 400;
  localparam int CHOKE_LEN   = 40;
  localparam int RANDOM_REQS = 1450;

  typedef struct {
    logic              kind;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
    int                gap;
    bit                drain;
    bit                choke;
  } request_t;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic [STAT_W-1:0] status;
    logic              now_empty;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;    // [31:0] item_data, [47:32] item_priority
  logic        s_axis_tuser = 1'b0;  // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [31:0] out_data
  logic [2:0]  m_axis_tuser;         // [1:0] status, [2] now_empty

  request_t          pending_requests[$];
  result_t           expected_results[$];
  logic [DATA_W-1:0] shadow_data[DEPTH];
  logic [PRIO_W-1:0] shadow_prio[DEPTH];
  int                shadow_count;
  request_t          cur_req;
  int                gap_left;
  int                choke_seq;
  int                choke_seen;
  int                choke_left;
  int                stall_left;
  bit                tx_quiet;
  bit                rx_quiet;
  int                idle_cycles;
  int                error_count;

  stable_priority_queue_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  task automatic predict_request(input request_t req);
    result_t res;
    int      pos;
    res.data = '0;
    if (req.kind == KIND_ENQ) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= req.prio) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_data[i] = shadow_data[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_data[pos] = req.data;
        shadow_prio[pos] = req.prio;
        shadow_count++;
        res.status = ST_ENQ;
      end
    end else begin
      if (shadow_count == 0) begin
        res.data   = '1;
        res.status = ST_EMPTY;
      end else begin
        res.data = shadow_data[0];
        for (int i = 0; i + 1 < shadow_count; i++) begin
          shadow_data[i] = shadow_data[i+1];
          shadow_prio[i] = shadow_prio[i+1];
        end
        shadow_count--;
        res.status = ST_DEQ;
      end
    end
    res.now_empty = (shadow_count == 0);
    expected_results.push_back(res);
  endtask

  task automatic queue_request(input logic kind, input logic [DATA_W-1:0] data,
                               input logic [PRIO_W-1:0] prio, input bit drain,
                               input bit choke);
    request_t req;
    req.kind  = kind;
    req.data  = data;
    req.prio  = prio;
    req.gap   = tx_quiet ? 0 : $urandom_range(0, 4);
    req.drain = drain;
    req.choke = choke;
    pending_requests.push_back(req);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    logic next_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      choke_seq     <= 0;
      gap_left      = 0;
      shadow_count  = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_request(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].drain && expected_results.size() != 0)) begin
          cur_req    = pending_requests.pop_front();
          gap_left   = cur_req.gap;
          next_valid = 1'b1;
          s_axis_tdata <= {cur_req.prio, cur_req.data};
          s_axis_tuser <= cur_req.kind;
          if (cur_req.choke) choke_seq <= choke_seq + 1;
        end
        s_axis_tvalid <= next_valid;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    result_t want;
    logic    next_ready;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      choke_left = 0;
      choke_seen = 0;
      rx_quiet   = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          if (error_count < 10)
            $display("unexpected result: data %h user %b", m_axis_tdata, m_axis_tuser);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tuser[1:0] !== want.status ||
              m_axis_tuser[2] !== want.now_empty) begin
            if (error_count < 10)
              $display("mismatch: expected data %h status %0d empty %0b, got %h %0d %0b",
                       want.data, want.status, want.now_empty,
                       m_axis_tdata, m_axis_tuser[1:0], m_axis_tuser[2]);
            error_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        stall_left = rx_quiet ? 0 : $urandom_range(0, 4);
      end
      if (choke_seq != choke_seen) begin
        choke_seen = choke_seq;
        choke_left = CHOKE_LEN;
      end
      if (choke_left > 0) begin
        choke_left--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      m_axis_tready <= next_ready;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int                total;
    int                seg_len;
    int                enq_pct;
    int                pick;
    logic              kind;
    logic [PRIO_W-1:0] prio;
    logic [PRIO_W-1:0] base_prio;
    bit                drain;
    idle_cycles = 0;
    error_count = 0;
    tx_quiet    = 1'b0;

    // empty dequeue, extreme values, ties in both priority extremes
    queue_request(KIND_DEQ, 32'h1234_5678, 16'hffff, 1'b0, 1'b0);
    queue_request(KIND_ENQ, 32'h7fff_ffff, 16'hffff, 1'b0, 1'b0);
    queue_request(KIND_ENQ, 32'h8000_0000, 16'h0000, 1'b0, 1'b0);
    queue_request(KIND_ENQ, 32'h0000_0000, 16'hffff, 1'b0, 1'b0);
    queue_request(KIND_ENQ, 32'hffff_ffff, 16'h0000, 1'b0, 1'b0);
    repeat (4) queue_request(KIND_DEQ, $urandom, 16'($urandom), 1'b0, 1'b0);
    queue_request(KIND_DEQ, 32'hffff_ffff, 16'h0000, 1'b0, 1'b0);
    // fill to the top, then overflow
    for (int i = 0; i <= DEPTH; i++)
      queue_request(KIND_ENQ, $urandom, 16'(i % 3), 1'b0, 1'b0);

    total = 0;
    while (total < RANDOM_REQS) begin
      seg_len   = $urandom_range(20, 60);
      enq_pct   = $urandom_range(15, 90);
      tx_quiet  = ($urandom_range(0, 3) == 0);
      base_prio = 16'($urandom);
      drain     = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < seg_len; n++) begin
        kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
        pick = $urandom_range(0, 9);
        if (pick < 4) prio = 16'($urandom_range(0, 3));
        else if (pick < 7) prio = 16'($urandom);
        else if (pick < 9) prio = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        else prio = base_prio + 16'($urandom_range(0, 2));
        queue_request(kind, $urandom, prio, drain && n == 0,
                      total == 400 || total == 1000);
        total++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      error_count += expected_results.size();
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue_top.sv
tb/sv/stable_priority_queue_top_test.sv
